@@ design/hqr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// shared types and constants for the handle queue with removal
// no dependencies

package hqr_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int HANDLE_BITS_DEF = 16;

  localparam int KIND_W = 3;
  localparam int HIN_W  = 16;
  localparam int POS_W  = 4;
  localparam int OCC_W  = 5;
  localparam int CAP_W  = 5;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [KIND_W-1:0] {
    K_APPEND  = 3'd0,
    K_POP_OLD = 3'd1,
    K_POP_NEW = 3'd2,
    K_REMOVE  = 3'd3,
    K_READ    = 3'd4
  } kind_t;

  typedef struct packed {
    logic shift_all;
    logic capture;
    logic remove_go;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ design/handle_queue_with_removal_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Ordered handle queue built as a chain of slot cells with append, pop oldest/newest,
// remove-by-match and read-at-position. Depends on hqr_pkg and hqr_cell.
//
// Append, both pops, reads and unused kinds finish from S_IDLE; a remove first registers
// a compare of every cell against the handle, then in S_REMOVE ripples the found flag
// down the chain and closes the gap. One operation is in flight at a time; the next is taken
// as soon as the result register is free or being drained. occupancy reports the
// fill count modulo 32. Reads reach only the first 16 entries (4-bit position).

module handle_queue_with_removal_core #(
  parameter int DEPTH       = hqr_pkg::DEPTH_DEF,
  parameter int HANDLE_BITS = hqr_pkg::HANDLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [hqr_pkg::IN_DATA_W-1:0] s_axis_tdata,   // handle_in[15:0], position[19:16]
  input  wire logic [hqr_pkg::KIND_W-1:0]    s_axis_tuser,   // kind[2:0]
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [hqr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // handle_out[15:0], occupancy[20:16]
  output logic                               m_axis_tuser,   // ok[0]
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [hqr_pkg::CAP_W-1:0]     cfg_data
);
  import hqr_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int HW   = HANDLE_BITS;
  localparam int RD_N = (DEPTH < (1 << POS_W)) ? DEPTH : (1 << POS_W);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_REMOVE = 2'b10
  } state_t;

  state_t            state, state_next;
  logic [CW-1:0]     fill, fill_next;
  logic [CAP_W-1:0]  cap_limit;
  cell_ctl_t         ctl;
  logic              do_append;
  logic              in_acc;
  logic              full;
  kind_t             kind;
  logic [63:0]       hin_ext;
  logic [HW-1:0]     key;
  logic [POS_W-1:0]  position;
  logic [DEPTH-1:0]  valid;
  logic [DEPTH:0]    valid_ext;
  logic [DEPTH-1:0]  load;
  logic [DEPTH:0]    carry;
  logic [HW-1:0]     q [DEPTH];
  logic [HW-1:0]     newest;
  logic [HW-1:0]     rd_val;
  logic              rd_hit;
  logic              res_fire;
  logic              res_ok;
  logic [HW-1:0]     res_h;
  logic [63:0]       res_ext;
  logic [31:0]       occ_ext;
  logic [31:0]       fill32;
  logic [31:0]       lim32;
  logic [HIN_W-1:0]  out_h;
  logic [OCC_W-1:0]  out_occ;
  logic              out_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_limit <= CAP_W'(16);
    end else if (cfg_valid) begin
      cap_limit <= cfg_data;
    end
  end

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign kind     = kind_t'(s_axis_tuser);
  assign hin_ext  = 64'(s_axis_tdata[HIN_W-1:0]);
  assign key      = hin_ext[HW-1:0];
  assign position = s_axis_tdata[HIN_W+POS_W-1:HIN_W];
  assign s_axis_tready = (state == S_IDLE) && (!m_axis_tvalid || m_axis_tready);

  assign fill32 = 32'(fill);
  assign lim32  = 32'(cap_limit);
  assign full   = (fill32 >= 32'(DEPTH)) ||
                  ((cap_limit != '0) && (lim32 <= 32'(DEPTH)) && (fill32 >= lim32));

  assign carry[0]         = 1'b0;
  assign valid_ext[DEPTH] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [HW-1:0] nbr;
    assign valid[i]     = fill > CW'(i);
    assign valid_ext[i] = valid[i];
    assign load[i]      = do_append && (fill == CW'(i));
    if (i == DEPTH - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = q[i+1];
    end
    hqr_cell #(.HW(HW)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .load      (load[i]),
      .valid     (valid[i]),
      .din       (key),
      .nbr       (nbr),
      .carry_in  (carry[i]),
      .carry_out (carry[i+1]),
      .q         (q[i])
    );
  end

  always_comb begin
    newest = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (valid_ext[i] && !valid_ext[i+1]) begin
        newest = newest | q[i];
      end
    end
  end

  always_comb begin
    rd_val = '0;
    rd_hit = 1'b0;
    for (int i = 0; i < RD_N; i++) begin
      if (valid[i] && (position == POS_W'(i))) begin
        rd_val = rd_val | q[i];
        rd_hit = 1'b1;
      end
    end
  end

  always_comb begin
    ctl        = '0;
    do_append  = 1'b0;
    fill_next  = fill;
    state_next = state;
    res_fire   = 1'b0;
    res_ok     = 1'b0;
    res_h      = '0;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          res_fire = 1'b1;
          case (kind)
            K_APPEND: begin
              if (!full) begin
                do_append = 1'b1;
                fill_next = fill + CW'(1);
                res_ok    = 1'b1;
              end
            end
            K_POP_OLD: begin
              if (fill != '0) begin
                res_h         = q[0];
                ctl.shift_all = 1'b1;
                fill_next     = fill - CW'(1);
                res_ok        = 1'b1;
              end
            end
            K_POP_NEW: begin
              if (fill != '0) begin
                res_h     = newest;
                fill_next = fill - CW'(1);
                res_ok    = 1'b1;
              end
            end
            K_REMOVE: begin
              ctl.capture = 1'b1;
              res_fire    = 1'b0;
              state_next  = S_REMOVE;
            end
            K_READ: begin
              if (rd_hit) begin
                res_h  = rd_val;
                res_ok = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_REMOVE: begin
        ctl.remove_go = 1'b1;
        res_fire      = 1'b1;
        state_next    = S_IDLE;
        if (carry[DEPTH]) begin
          fill_next = fill - CW'(1);
          res_ok    = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
    end
  end

  assign res_ext = 64'(res_h);
  assign occ_ext = 32'(fill_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_ok  <= res_ok;
      out_h   <= res_ext[HIN_W-1:0];
      out_occ <= occ_ext[OCC_W-1:0];
    end
  end

  assign m_axis_tuser = out_ok;
  assign m_axis_tdata = {{(OUT_DATA_W - HIN_W - OCC_W){1'b0}}, out_occ, out_h};

endmodule

`default_nettype wire

@@ design/hqr_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// one slot of the queue chain: holds a handle, compares it, takes its neighbor's value
// depends on hqr_pkg

module hqr_cell #(
  parameter int HW = 16
) (
  input  wire logic             clk,
  input  wire hqr_pkg::cell_ctl_t ctl,
  input  wire logic             load,
  input  wire logic             valid,
  input  wire logic [HW-1:0]    din,
  input  wire logic [HW-1:0]    nbr,
  input  wire logic             carry_in,
  output logic                  carry_out,
  output logic [HW-1:0]         q
);
  import hqr_pkg::*;

  logic hit;

  assign carry_out = carry_in | hit;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      hit <= valid && (q == din);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= din;
    end else if (ctl.shift_all || (ctl.remove_go && carry_out)) begin
      q <= nbr;
    end
  end

endmodule

`default_nettype wire

@@ design/hqr_check.sv @@
`timescale 1ns / 1ps
`default_nettype none
// port-level checks for the handle queue with removal, bound to the top level
// depends on hqr_pkg and handle_queue_with_removal_core

module hqr_check #(
  parameter int DEPTH = hqr_pkg::DEPTH_DEF
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [hqr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                          m_axis_tuser
);
  import hqr_pkg::*;

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[15:0] == 16'd0))
    else $error("failed transaction carries a nonzero handle");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((DEPTH > 31) || (32'(m_axis_tdata[20:16]) <= 32'(DEPTH))))
    else $error("occupancy beyond depth");

  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while result stalled");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
                                           && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind handle_queue_with_removal_core hqr_check #(.DEPTH(DEPTH)) u_hqr_check (.*);

`default_nettype wire
